@@ sv/smf_pkg.sv @@
// Package for the sliding window median filter: sample type, window bounds
// and the struct that the core broadcasts to every window cell.
// No dependencies.
package smf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int WINDOW_DEF = 9;
   localparam int WINDOW_MIN = 3;
   localparam int WINDOW_MAX = 63;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Signals every cell sees in the same cycle.
   typedef struct packed {
      logic       shift;       // a sample transaction is taken this cycle
      logic       leave;       // the oldest sample drops out of a full window
      sample_type new_sample;  // sample entering at the head of the chain
      sample_type oldest;      // sample leaving at the tail of the chain
   } bcast_type;

endpackage

@@ sv/sliding_window_median_filter_core.sv @@
// Sliding window median filter core: a chain of WINDOW cells, each holding
// one sample and its rank, ranks kept current as samples shift through.
// One sample per cycle while the output is not stalled by rsp_tready.
// The first median follows the WINDOW-th sample after reset; earlier
// samples only fill the chain. Synchronous active-high reset clears the
// fill count and the output valid flags. Depends on smf_pkg and smf_cell.
module sliding_window_median_filter_core #(
   parameter int WINDOW = smf_pkg::WINDOW_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  smf_pkg::sample_type req_tdata,   // [15:0] sample
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output smf_pkg::sample_type rsp_tdata    // [15:0] median
);
   import smf_pkg::*;

   localparam int RANK_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int MID    = (WINDOW - 1) / 2;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        rsp_data_ff, rsp_data_in;

   bcast_type         bcast;
   logic              accept, full, produce, load;
   logic [RANK_W-1:0] head_rank;
   logic [WINDOW-1:0] hit;
   logic [WINDOW-1:0] le;

   sample_type        val     [WINDOW];
   logic [RANK_W-1:0] rank    [WINDOW];
   logic [RANK_W-1:0] rank_nx [WINDOW];

   assign full    = fill_ff == FILL_W'(WINDOW);
   assign load    = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || load;
   assign accept  = req_tvalid && req_tready;
   assign produce = accept && (fill_ff >= FILL_W'(WINDOW - 1));

   assign bcast.shift      = accept;
   assign bcast.leave      = full;
   assign bcast.new_sample = req_tdata;
   assign bcast.oldest     = val[WINDOW-1];

   // Rank of the new sample: valid samples that stay and are not above it.
   always_comb begin
      head_rank = '0;
      for (int i = 0; i < WINDOW - 1; i++) begin
         if ((FILL_W'(i) < fill_ff) && le[i]) begin
            head_rank = head_rank + RANK_W'(1);
         end
      end
   end

   for (genvar g = 0; g < WINDOW; g++) begin : g_cell
      sample_type        src_val;
      logic [RANK_W-1:0] src_rank;

      if (g == 0) begin : g_head
         assign src_val  = req_tdata;
         assign src_rank = head_rank;
      end else begin : g_link
         assign src_val  = val[g-1];
         assign src_rank = rank_nx[g-1];
      end

      smf_cell #(.RANK_W(RANK_W)) u_cell (
         .clock     (clock),
         .bcast     (bcast),
         .val_in    (src_val),
         .rank_in   (src_rank),
         .val_out   (val[g]),
         .rank_out  (rank[g]),
         .rank_next (rank_nx[g]),
         .le_out    (le[g])
      );

      assign hit[g] = rank[g] == RANK_W'(MID);
   end

   // Once full, ranks are a permutation, so exactly one cell hits.
   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < WINDOW; i++) begin
         rsp_data_in = rsp_data_in | (val[i] & {SAMPLE_W{hit[i]}});
      end
   end

   always_comb begin
      fill_in      = (accept && !full) ? fill_ff + FILL_W'(1) : fill_ff;
      pend_in      = produce ? 1'b1 : (load ? 1'b0 : pend_ff);
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_one_median : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $onehot(hit))
      else $error("median rank not held by exactly one cell");

   a_pend_full : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> full)
      else $error("result pending before the window filled");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("loaded median not presented");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !load) |=> pend_ff && $stable(fill_ff))
      else $error("pending median overwritten");

endmodule

@@ sv/smf_cell.sv @@
// One window cell: holds a sample and its rank within the window and hands
// both, with the rank brought up to date, to the next cell on every shift.
// Depends on smf_pkg.
module smf_cell #(
   parameter int RANK_W = 4
) (
   input  logic                clock,
   input  smf_pkg::bcast_type  bcast,
   input  smf_pkg::sample_type val_in,
   input  logic [RANK_W-1:0]   rank_in,
   output smf_pkg::sample_type val_out,
   output logic [RANK_W-1:0]   rank_out,
   output logic [RANK_W-1:0]   rank_next,
   output logic                le_out
);
   import smf_pkg::*;

   sample_type        val_ff;
   logic [RANK_W-1:0] rank_ff;
   logic              drop_below;
   logic              add_below;

   // Ties are ordered by age, older first. The leaving sample is the oldest,
   // so it ranks below this one when equal; the new one ranks above.
   assign drop_below = bcast.leave && (bcast.oldest <= val_ff);
   assign add_below  = bcast.new_sample < val_ff;

   assign rank_next = rank_ff - {{(RANK_W-1){1'b0}}, drop_below}
                              + {{(RANK_W-1){1'b0}}, add_below};
   assign le_out    = val_ff <= bcast.new_sample;
   assign val_out   = val_ff;
   assign rank_out  = rank_ff;

   always_ff @(posedge clock) begin
      if (bcast.shift) begin
         val_ff  <= val_in;
         rank_ff <= rank_in;
      end
   end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for sliding_window_median_filter_core: directed
// samples, then random sample streams with random idling on both streams.
// Depends on smf_pkg and the filter core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import smf_pkg::*;

   localparam int WIN         = WINDOW_DEF;
   localparam int RANDOM_CNT  = 1400;
   localparam int CALM_CNT    = 150;
   localparam int CYCLE_LIMIT = 400000;

   localparam sample_type S_MIN = 16'sh8000;
   localparam sample_type S_MAX = 16'sh7FFF;
   localparam sample_type S_ZERO = 16'sh0000;

   typedef enum logic [1:0] {
      ROW_NONE,     // window still filling, no median may appear
      ROW_VALUE,    // median typed in the row
      ROW_PREDICT   // median taken from the window model
   } row_kind_type;

   typedef struct {
      sample_type   sample;
      row_kind_type kind;
      sample_type   median;
   } stim_row_type;

   localparam int DIRECTED_CNT = 23;

   // Fill with the most negative value, then push the most positive value
   // in until it covers the middle rank, then a mix of signs and ties.
   stim_row_type stim_rows [DIRECTED_CNT] = '{
      '{S_MIN, ROW_NONE, S_ZERO}, '{S_MIN, ROW_NONE, S_ZERO},
      '{S_MIN, ROW_NONE, S_ZERO}, '{S_MIN, ROW_NONE, S_ZERO},
      '{S_MIN, ROW_NONE, S_ZERO}, '{S_MIN, ROW_NONE, S_ZERO},
      '{S_MIN, ROW_NONE, S_ZERO}, '{S_MIN, ROW_NONE, S_ZERO},
      '{S_MIN, ROW_VALUE, S_MIN},
      '{S_MAX, ROW_VALUE, S_MIN}, '{S_MAX, ROW_VALUE, S_MIN},
      '{S_MAX, ROW_VALUE, S_MIN}, '{S_MAX, ROW_VALUE, S_MIN},
      '{S_MAX, ROW_VALUE, S_MAX},
      '{16'sh0000, ROW_PREDICT, S_ZERO}, '{16'shFFFF, ROW_PREDICT, S_ZERO},
      '{16'sh0001, ROW_PREDICT, S_ZERO}, '{16'sh5555, ROW_PREDICT, S_ZERO},
      '{16'shAAAA, ROW_PREDICT, S_ZERO}, '{16'sh0000, ROW_PREDICT, S_ZERO},
      '{16'sh0000, ROW_PREDICT, S_ZERO}, '{16'shFFFF, ROW_PREDICT, S_ZERO},
      '{16'sh0001, ROW_PREDICT, S_ZERO}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   sample_type req_tdata;   // [15:0] sample
   logic       rsp_tvalid;
   logic       rsp_tready;
   sample_type rsp_tdata;   // [15:0] median

   // Window model, newest sample at index 0.
   sample_type window_hist [WIN];
   int         hist_count = 0;

   sample_type pending_medians [$];
   sample_type drift_base = 16'sh0000;

   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  calm = 1'b0;
   int  samples_sent = 0;
   int  medians_checked = 0;
   int  mismatches = 0;
   int  cycle_count = 0;

   sliding_window_median_filter_core #(
      .WINDOW(WIN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shifts a sample into the window model; once the window is full the
   // median is the middle entry of a sorted copy.
   task automatic shift_in_sample(input sample_type s, output bit produced,
                                  output sample_type median);
      sample_type ordered [WIN];
      sample_type t;
      for (int i = WIN - 1; i > 0; i--)
         window_hist[i] = window_hist[i-1];
      window_hist[0] = s;
      if (hist_count < WIN)
         hist_count++;
      produced = (hist_count == WIN);
      median = S_ZERO;
      if (produced) begin
         ordered = window_hist;
         for (int i = 0; i < WIN - 1; i++)
            for (int j = 0; j < WIN - 1 - i; j++)
               if (ordered[j] > ordered[j+1]) begin
                  t = ordered[j];
                  ordered[j] = ordered[j+1];
                  ordered[j+1] = t;
               end
         median = ordered[(WIN - 1) / 2];
      end
   endtask

   task automatic feed_sample(input sample_type s, input row_kind_type kind,
                              input sample_type typed_median);
      bit         produced;
      sample_type predicted;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      shift_in_sample(s, produced, predicted);
      if (kind == ROW_VALUE)
         pending_medians.push_back(typed_median);
      else if (kind == ROW_PREDICT && produced)
         pending_medians.push_back(predicted);
      samples_sent++;
   endtask

   // Mix of full-range noise, tight clusters that force ties, extremes and a
   // slowly drifting level that wraps around the signed range.
   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         return sample_type'($urandom);
      if (pick < 6)
         return sample_type'($urandom_range(0, 6)) - 16'sd3;
      if (pick == 6)
         case ($urandom_range(0, 3))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 16'shFFFF;
            default: return S_ZERO;
         endcase
      drift_base = drift_base + sample_type'($urandom_range(0, 512)) - 16'sd256;
      return drift_base + sample_type'($urandom_range(0, 15)) - 16'sd8;
   endfunction

   // Result side: accept for a while, then stall for a burst now and then.
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected median transaction, got %0d", $time, rsp_tdata);
            mismatches++;
         end else begin
            if (rsp_tdata !== pending_medians[0]) begin
               $display("%0t: median mismatch, expected %0d, got %0d",
                        $time, pending_medians[0], rsp_tdata);
               mismatches++;
            end
            void'(pending_medians.pop_front());
            medians_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d medians outstanding", $time,
                  pending_medians.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= S_ZERO;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_pct  = 30;
      stall_pct = 30;
      foreach (stim_rows[r])
         feed_sample(stim_rows[r].sample, stim_rows[r].kind, stim_rows[r].median);

      for (int n = 0; n < RANDOM_CNT; n++) begin
         // Idling pressure changes every hundred samples, sometimes to none.
         if (n % 100 == 0) begin
            case ($urandom_range(0, 3))
               0:       begin idle_pct = 0;  stall_pct = 0;  end
               1:       begin idle_pct = 15; stall_pct = 40; end
               2:       begin idle_pct = 50; stall_pct = 10; end
               default: begin idle_pct = 70; stall_pct = 80; end
            endcase
         end
         if (n == RANDOM_CNT - CALM_CNT)
            calm = 1'b1;
         feed_sample(random_sample(), ROW_PREDICT, S_ZERO);
      end
      req_tvalid <= 1'b0;

      while (pending_medians.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_medians.size() != 0)
         mismatches++;

      $display("Streamed %0d samples (%0d directed) with random idling on both sides,",
               samples_sent, DIRECTED_CNT);
      $display("checked %0d medians over a window of %0d, %0d mismatches.",
               medians_checked, WIN, mismatches);
      if (mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
